@@ src/lsot_pkg.sv @@
// Shared types, codes and sizes of the layer stacking table.
package lsot_pkg;

    localparam int LAYERS = 16;
    // slot numbers are 4 bits wide on the ports; the table index follows the depth
    localparam int SLOT_W = 4;
    localparam int IDX_W  = $clog2(LAYERS);
    localparam int POS_W  = 5;
    localparam int DIST_W = POS_W + 1;
    localparam int REQ_W  = 8;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFREE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTUSED = 2'd2;

    // hidden layer / empty stack marker
    localparam logic signed [POS_W-1:0]  POS_HIDDEN  = '1;
    localparam logic signed [DIST_W-1:0] DIST_HIDDEN = '1;
    localparam logic signed [DIST_W-1:0] DIST_ONE    = 6'sd1;

    typedef struct packed {
        logic load;
        logic eval;
        logic step;
        logic place;
        logic emit;
    } lsot_cmd_t;

    typedef struct packed {
        logic step_pending;
    } lsot_stat_t;

endpackage

@@ src/lsot_ctrl.sv @@
// Sequencer: accept, evaluate, shift loop, place and result hand-off.
module lsot_ctrl
    import lsot_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  lsot_stat_t stat,
    output lsot_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (stat.step_pending)
                begin
                    cmd.step = 1'b1;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/lsot_dp.sv @@
// Datapath: slot state, order table, clamp and shift unit, result register.
module lsot_dp
    import lsot_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lsot_cmd_t                cmd,
    output lsot_stat_t               stat,
    input  logic [KIND_W-1:0]        in_kind,
    input  logic [SLOT_W-1:0]        in_slot,
    input  logic signed [REQ_W-1:0]  in_req,
    output logic [STAT_W-1:0]        out_status,
    output logic [SLOT_W-1:0]        out_slot,
    output logic signed [POS_W-1:0]  out_height,
    output logic signed [POS_W-1:0]  out_top,
    output logic                     out_redraw
);

    localparam int WIDE_W = REQ_W + 1;
    localparam logic signed [WIDE_W-1:0] WIDE_HIDDEN = '1;

    logic [KIND_W-1:0]        kind_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic signed [REQ_W-1:0]  req_reg;

    logic                     used_reg [LAYERS];
    logic signed [POS_W-1:0]  pos_reg  [LAYERS];
    logic [SLOT_W-1:0]        ot_reg   [LAYERS];
    logic signed [POS_W-1:0]  top_reg;

    logic                     move_reg;
    logic                     up_reg;
    logic                     grow_reg;
    logic signed [DIST_W-1:0] d_reg;
    logic signed [DIST_W-1:0] bound_reg;
    logic signed [DIST_W-1:0] h_reg;
    logic [STAT_W-1:0]        res_status_reg;
    logic [SLOT_W-1:0]        res_slot_reg;
    logic                     res_redraw_reg;

    logic [STAT_W-1:0]        out_status_reg;
    logic [SLOT_W-1:0]        out_slot_reg;
    logic signed [POS_W-1:0]  out_height_reg;
    logic signed [POS_W-1:0]  out_top_reg;
    logic                     out_redraw_reg;

    logic [IDX_W-1:0]         sidx;
    logic                     free_found;
    logic [IDX_W-1:0]         free_idx;
    logic signed [DIST_W-1:0] old_pos;
    logic signed [DIST_W-1:0] top_ext;
    logic signed [DIST_W-1:0] limit;
    logic signed [WIDE_W-1:0] req_w;
    logic signed [WIDE_W-1:0] lim_w;
    logic signed [WIDE_W-1:0] hc_w;
    logic signed [DIST_W-1:0] h_new;
    logic                     move_c;
    logic                     up_c;
    logic signed [DIST_W-1:0] d_start;
    logic signed [DIST_W-1:0] bound_c;
    logic signed [DIST_W-1:0] src;
    logic [SLOT_W-1:0]        moved;
    logic [STAT_W-1:0]        status_c;
    logic [SLOT_W-1:0]        slot_c;

    assign sidx = slot_reg[IDX_W-1:0];

    // lowest unused slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = LAYERS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // clamp and move planning
    always_comb
    begin
        old_pos = {pos_reg[sidx][POS_W-1], pos_reg[sidx]};
        top_ext = {top_reg[POS_W-1], top_reg};
        limit   = old_pos[DIST_W-1] ? top_ext + DIST_ONE : top_ext;
        req_w   = {req_reg[REQ_W-1], req_reg};
        lim_w   = {{(WIDE_W-DIST_W){limit[DIST_W-1]}}, limit};
        hc_w    = (req_w > lim_w) ? lim_w : req_w;
        if (hc_w < WIDE_HIDDEN)
        begin
            hc_w = WIDE_HIDDEN;
        end
        if (kind_reg == KIND_FREE)
        begin
            h_new  = DIST_HIDDEN;
            move_c = !old_pos[DIST_W-1];
        end
        else
        begin
            h_new  = hc_w[DIST_W-1:0];
            move_c = (h_new != old_pos);
        end
        up_c = !h_new[DIST_W-1] && (old_pos[DIST_W-1] || (old_pos > h_new));
        if (up_c)
        begin
            d_start = old_pos[DIST_W-1] ? top_ext + DIST_ONE : old_pos;
            bound_c = h_new;
        end
        else
        begin
            d_start = old_pos;
            bound_c = h_new[DIST_W-1] ? top_ext : h_new;
        end
    end

    always_comb
    begin
        status_c = ST_OK;
        slot_c   = '0;
        unique case (kind_reg)
            KIND_ALLOC:
            begin
                status_c = free_found ? ST_OK : ST_NOFREE;
                slot_c   = free_found ? SLOT_W'(free_idx) : '0;
            end
            KIND_SET, KIND_FREE:
            begin
                status_c = used_reg[sidx] ? ST_OK : ST_NOTUSED;
                slot_c   = slot_reg;
            end
            default:
            begin
                status_c = ST_OK;
                slot_c   = '0;
            end
        endcase
    end

    // one table entry per step: up moves pull from below, down moves from above
    assign src   = up_reg ? d_reg - DIST_ONE : d_reg + DIST_ONE;
    assign moved = ot_reg[src[IDX_W-1:0]];

    assign stat.step_pending = move_reg && (up_reg ? (d_reg > bound_reg) : (d_reg < bound_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAYERS; i++)
            begin
                used_reg[i] <= 1'b0;
                pos_reg[i]  <= POS_HIDDEN;
            end
            top_reg  <= POS_HIDDEN;
            move_reg <= 1'b0;
        end
        else
        begin
            if (cmd.eval)
            begin
                move_reg <= 1'b0;
                unique case (kind_reg)
                    KIND_ALLOC:
                    begin
                        if (free_found)
                        begin
                            used_reg[free_idx] <= 1'b1;
                            pos_reg[free_idx]  <= POS_HIDDEN;
                        end
                    end
                    KIND_SET, KIND_FREE:
                    begin
                        if (used_reg[sidx])
                        begin
                            move_reg <= move_c;
                            if (kind_reg == KIND_FREE)
                            begin
                                used_reg[sidx] <= 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        move_reg <= 1'b0;
                    end
                endcase
            end
            if (cmd.step)
            begin
                pos_reg[moved] <= d_reg[POS_W-1:0];
            end
            if (cmd.place && move_reg)
            begin
                move_reg <= 1'b0;
                if (h_reg[DIST_W-1])
                begin
                    pos_reg[sidx] <= POS_HIDDEN;
                    top_reg       <= top_reg - POS_W'(1);
                end
                else
                begin
                    pos_reg[sidx] <= h_reg[POS_W-1:0];
                    if (grow_reg)
                    begin
                        top_reg <= top_reg + POS_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            slot_reg <= in_slot;
            req_reg  <= in_req;
        end
        if (cmd.eval)
        begin
            up_reg         <= up_c;
            grow_reg       <= old_pos[DIST_W-1];
            d_reg          <= d_start;
            bound_reg      <= bound_c;
            h_reg          <= h_new;
            res_status_reg <= status_c;
            res_slot_reg   <= slot_c;
            res_redraw_reg <= (kind_reg == KIND_SET || kind_reg == KIND_FREE)
                              && used_reg[sidx] && move_c;
        end
        if (cmd.step)
        begin
            ot_reg[d_reg[IDX_W-1:0]] <= moved;
            d_reg <= up_reg ? d_reg - DIST_ONE : d_reg + DIST_ONE;
        end
        if (cmd.place && move_reg && !h_reg[DIST_W-1])
        begin
            ot_reg[h_reg[IDX_W-1:0]] <= slot_reg;
        end
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_height_reg <= (kind_reg == KIND_SET && res_status_reg == ST_OK)
                              ? pos_reg[sidx] : POS_HIDDEN;
            out_top_reg    <= top_reg;
            out_redraw_reg <= res_redraw_reg;
        end
    end

    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_height = out_height_reg;
    assign out_top    = out_top_reg;
    assign out_redraw = out_redraw_reg;

endmodule

@@ src/layer_stack_order_table_core.sv @@
// An accepted item passes evaluate, the order table shift and place before its result
// shows on m_tvalid. The shift moves one table entry per cycle for each of the n layers
// (0 to LAYERS - 1) a set-height or free moves; allocate, errors and unchanged heights
// need no shift. A new item is taken only after the last result is in the output register.
// Reset (rst_n low, asynchronous): all slots unused and hidden, stack empty,
// no result pending. The order table itself is not cleared.
module layer_stack_order_table_core
    import lsot_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // request items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] slot, [11:4] req_height, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [1:0] status, [5:2] slot_out, [10:6] assigned_height,
                                   // [15:11] top_index, [16] redraw, [23:17] zero
);

    lsot_cmd_t               cmd;
    lsot_stat_t              stat;
    logic [STAT_W-1:0]       res_status;
    logic [SLOT_W-1:0]       res_slot;
    logic signed [POS_W-1:0] res_height;
    logic signed [POS_W-1:0] res_top;
    logic                    res_redraw;

    // Controller: one item in flight; the output register lets the next
    // item in while the last result waits for m_tready.
    lsot_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: slot flags, positions, order table and the shift unit.
    lsot_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_kind    (s_tuser[KIND_W-1:0]),
        .in_slot    (s_tdata[SLOT_W-1:0]),
        .in_req     (s_tdata[SLOT_W+REQ_W-1:SLOT_W]),
        .out_status (res_status),
        .out_slot   (res_slot),
        .out_height (res_height),
        .out_top    (res_top),
        .out_redraw (res_redraw)
    );

    assign m_tdata = {7'b0, res_redraw, res_top, res_height, res_slot, res_status};

endmodule

@@ src/lsot_checker.sv @@
// Port-level checks of the layer stacking table, bound to the top level.
module lsot_checker
    import lsot_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // one item in flight: the input closes right after an accept
    a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'b11)
        else $error("undefined status code");

    // failed requests never change the order
    a_err_no_redraw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != ST_OK |-> !m_tdata[16] && m_tdata[10:6] == 5'h1f)
        else $error("failed request reported a move");

    // a layer never sits above the top of the stack
    a_height_le_top: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[10:6]) <= $signed(m_tdata[15:11]))
        else $error("assigned height above top index");

endmodule

bind layer_stack_order_table_core lsot_checker u_lsot_checker (.*);

@@ dv/layer_stack_order_table_core_tb.sv @@
// Testbench for layer_stack_order_table_core: directed table plus random requests, scoreboarded.
module layer_stack_order_table_core_tb;
    import lsot_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // kind 3 is not decoded by the block; it still answers with one item
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
    localparam int RANDOM_ITEMS   = 1080;
    localparam int QUIET_LIMIT    = 2000;   // cycles with no item moved on either side
    localparam int TAIL_CYCLES    = 40;     // wait after the last result before the final report
    localparam int IDLE_PERCENT   = 28;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [SLOT_W-1:0]       slot;
        logic signed [POS_W-1:0] height;
        logic signed [POS_W-1:0] top;
        logic                    redraw;
    } layer_result_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [REQ_W-1:0]  req;
        logic [4:0]        reps;    // row is sent this many times
        logic              known;   // result below is typed in, else predicted
        layer_result_t     res;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 21;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // mirror of the stacking table
    bit layer_used   [LAYERS];
    int layer_height [LAYERS];
    int stack_at     [LAYERS];
    int stack_top;

    layer_result_t pending_results[$];
    int  error_count = 0;
    int  quiet_cycles = 0;
    bit  steady = 1'b0;     // both sides stop idling while set

    layer_stack_order_table_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Move slot s to (clamped) height h, shifting the layers in between.
    // Returns 1 when the stacking order changed.
    function automatic bit restack_layer(int s, int h);
        int old;
        int lim;
        int k;
        old = layer_height[s];
        lim = (old >= 0) ? stack_top : stack_top + 1;
        if (h > lim)
            h = lim;
        if (h < -1)
            h = -1;
        if (h == old)
            return 1'b0;
        if (old > h) begin
            if (h >= 0) begin
                // sink: layers from h up to old-1 move up one place
                for (k = old; k > h; k--) begin
                    stack_at[k] = stack_at[k - 1];
                    layer_height[stack_at[k]] = k;
                end
                stack_at[h] = s;
            end
            else begin
                // hide: close the gap, top always drops
                for (k = old; k < stack_top; k++) begin
                    stack_at[k] = stack_at[k + 1];
                    layer_height[stack_at[k]] = k;
                end
                stack_top--;
            end
        end
        else if (old >= 0) begin
            // raise a shown layer
            for (k = old; k < h; k++) begin
                stack_at[k] = stack_at[k + 1];
                layer_height[stack_at[k]] = k;
            end
            stack_at[h] = s;
        end
        else begin
            // show a hidden layer: open a gap at h
            for (k = stack_top; k >= h; k--) begin
                stack_at[k + 1] = stack_at[k];
                layer_height[stack_at[k + 1]] = k + 1;
            end
            stack_at[h] = s;
            stack_top++;
        end
        layer_height[s] = h;
        return 1'b1;
    endfunction

    function automatic layer_result_t apply_request(logic [KIND_W-1:0] kind,
                                                    logic [SLOT_W-1:0] slot,
                                                    logic [REQ_W-1:0] req);
        layer_result_t r;
        int s;
        int h;
        int i;
        s = int'(slot);
        h = int'($signed(req));
        r.status = ST_OK;
        r.slot   = '0;
        r.height = POS_HIDDEN;
        r.redraw = 1'b0;
        if (kind == KIND_ALLOC) begin
            r.status = ST_NOFREE;
            for (i = 0; i < LAYERS; i++) begin
                if (!layer_used[i]) begin
                    layer_used[i]   = 1'b1;
                    layer_height[i] = -1;
                    r.status = ST_OK;
                    r.slot   = SLOT_W'(i);
                    break;
                end
            end
        end
        else if (kind == KIND_SET || kind == KIND_FREE) begin
            r.slot = slot;
            if (s >= LAYERS || !layer_used[s])
                r.status = ST_NOTUSED;
            else if (kind == KIND_SET) begin
                r.redraw = restack_layer(s, h);
                r.height = POS_W'(layer_height[s]);
            end
            else begin
                if (layer_height[s] >= 0)
                    r.redraw = restack_layer(s, -1);
                layer_used[s] = 1'b0;
            end
        end
        r.top = POS_W'(stack_top);
        return r;
    endfunction

    // Drive one request, wait for its handshake, then queue what it should produce.
    task automatic send_request(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                logic [REQ_W-1:0] req, bit known, layer_result_t typed);
        layer_result_t predicted;
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, req, slot};
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_request(kind, slot, req);
        pending_results.push_back(known ? typed : predicted);
    endtask

    // Pick a slot in use most of the time so set-height and free do real work.
    function automatic logic [SLOT_W-1:0] pick_slot();
        int live[$];
        int i;
        for (i = 0; i < LAYERS; i++)
            if (layer_used[i])
                live.push_back(i);
        if (live.size() == 0 || $urandom_range(99) < 15)
            return SLOT_W'($urandom_range(LAYERS - 1));
        return SLOT_W'(live[$urandom_range(live.size() - 1)]);
    endfunction

    // Receiver side: random back-pressure except during the steady stretch.
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);

    // Result checker and watchdog.
    always @(posedge clk) begin
        layer_result_t got;
        layer_result_t want;
        got = '{status: m_tdata[1:0], slot: m_tdata[5:2], height: m_tdata[10:6],
                top: m_tdata[15:11], redraw: m_tdata[16]};
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result item %h", $realtime, m_tdata);
            end
            else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.height !== want.height || got.top !== want.top ||
                    got.redraw !== want.redraw) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $write("%0t: mismatch expected st=%0d slot=%0d h=%0d top=%0d rd=%0d,",
                               $realtime, want.status, want.slot, want.height,
                               want.top, want.redraw);
                        $display(" got st=%0d slot=%0d h=%0d top=%0d rd=%0d",
                                 got.status, got.slot, got.height, got.top, got.redraw);
                    end
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Directed rows: error paths, clamping at both ends, hiding the topmost layer,
    // unchanged height, free of a shown layer, unknown kind, table full.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{KIND_FREE,    3,    0, 1, 1, '{ST_NOTUSED, 3,  POS_HIDDEN, POS_HIDDEN, 0}},
        '{KIND_SET,    15,    5, 1, 1, '{ST_NOTUSED, 15, POS_HIDDEN, POS_HIDDEN, 0}},
        '{KIND_UNKNOWN, 15, 8'h80, 1, 1, '{ST_OK,    0,  POS_HIDDEN, POS_HIDDEN, 0}},
        '{KIND_ALLOC,   0,    0, 1, 1, '{ST_OK,      0,  POS_HIDDEN, POS_HIDDEN, 0}},
        '{KIND_ALLOC,  15, 8'hFF, 1, 1, '{ST_OK,     1,  POS_HIDDEN, POS_HIDDEN, 0}},
        // hidden layer clamps to top + 1
        '{KIND_SET,     0, 8'h7F, 1, 1, '{ST_OK,     0,  0,          0,          1}},
        // below -1 clamps to -1: already hidden, nothing moves
        '{KIND_SET,     1, 8'h80, 1, 1, '{ST_OK,     1,  POS_HIDDEN, 0,          0}},
        '{KIND_SET,     1,    5, 1, 1, '{ST_OK,      1,  1,          1,          1}},
        // shown layer clamps to top
        '{KIND_SET,     0, 8'h7F, 1, 1, '{ST_OK,     0,  1,          1,          1}},
        '{KIND_SET,     0,    1, 1, 1, '{ST_OK,      0,  1,          1,          0}},
        // hiding the topmost layer lowers top
        '{KIND_SET,     0, 8'hFF, 1, 1, '{ST_OK,     0,  POS_HIDDEN, 0,          1}},
        '{KIND_SET,     0,    0, 1, 0, '0},
        '{KIND_FREE,    0,    0, 1, 1, '{ST_OK,      0,  POS_HIDDEN, 0,          1}},
        '{KIND_FREE,    0,    0, 1, 1, '{ST_NOTUSED, 0,  POS_HIDDEN, 0,          0}},
        '{KIND_ALLOC,   0,    0, 15, 0, '0},
        '{KIND_ALLOC,   0,    0, 1, 1, '{ST_NOFREE,  0,  POS_HIDDEN, 0,          0}},
        '{KIND_SET,    15,    0, 1, 0, '0},
        '{KIND_SET,     7, 8'hFB, 1, 0, '0},
        '{KIND_SET,     1, 8'h7F, 1, 0, '0},
        '{KIND_SET,    15, 8'h7F, 1, 0, '0},
        '{KIND_FREE,    1,    0, 1, 0, '0}
    };

    initial begin
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [REQ_W-1:0]  req;
        int alloc_bias;
        int pick;
        int n;
        int i;

        for (i = 0; i < LAYERS; i++) begin
            layer_used[i]   = 1'b0;
            layer_height[i] = -1;
            stack_at[i]     = 0;
        end
        stack_top = -1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            for (n = 0; n < directed_rows[r].reps; n++)
                send_request(directed_rows[r].kind, directed_rows[r].slot,
                             directed_rows[r].req, directed_rows[r].known,
                             directed_rows[r].res);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // steady stretch with no idling on either side
            if (n == 400)
                steady <= 1'b1;
            if (n == 600)
                steady <= 1'b0;
            // hold off until the block has drained
            if (n == 700) begin
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            // alternate between filling and draining the table
            alloc_bias = ((n / 128) % 2) ? 40 : 12;
            pick = $urandom_range(99);
            slot = pick_slot();
            req  = REQ_W'($urandom);
            if (pick < alloc_bias) begin
                kind = KIND_ALLOC;
                slot = SLOT_W'($urandom);
            end
            else if (pick < alloc_bias + 3)
                kind = KIND_UNKNOWN;
            else if (pick < alloc_bias + 18)
                kind = KIND_FREE;
            else begin
                kind = KIND_SET;
                // mostly heights around the live stack, some anywhere in range
                if ($urandom_range(99) < 75)
                    req = REQ_W'($urandom_range(stack_top + 3) - 1);
            end
            send_request(kind, slot, req, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
